// ===== sv/sarm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the saturating adder for the audio router/mixer.
// No dependencies; imported by every other file of the block but sarm_ram.
package sarm_pkg;

	localparam int NUM_CHANNELS  = 16;
	localparam int BLOCK_SAMPLES = 128;
	localparam int CH_W          = 4;
	localparam int POS_W         = $clog2(BLOCK_SAMPLES);
	localparam int SMP_W         = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOARD_ROUTE  = 2'd0,
		CFG_BOARD_SELECT = 2'd1,
		CFG_MON_ROUTE    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] board_route;
		logic [CFG_W-1:0] board_select;
		logic [CFG_W-1:0] monitor_route;
	} cfg_t;

	// One accumulator entry: the three bus sums of one sample position.
	typedef struct packed {
		logic signed [SMP_W-1:0] monitor;
		logic signed [SMP_W-1:0] board1;
		logic signed [SMP_W-1:0] board0;
	} acc_t;

	localparam int ACC_W = $bits(acc_t);

	function automatic logic signed [SMP_W-1:0] sat_add(
		input logic signed [SMP_W-1:0] a,
		input logic signed [SMP_W-1:0] b
	);
		logic signed [SMP_W:0] sum;
		logic signed [SMP_W-1:0] res;
		sum = {a[SMP_W-1], a} + {b[SMP_W-1], b};
		if (sum[SMP_W] != sum[SMP_W-1]) begin
			res = sum[SMP_W] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
		end else begin
			res = sum[SMP_W-1:0];
		end
		return res;
	endfunction

endpackage

// ===== sv/sarm_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sarm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/sarm_mix.sv =====
`timescale 1ns / 1ps
// Routing decode and saturating adds of one sample onto one accumulator entry.
// Depends on sarm_pkg.
module sarm_mix (
	input  sarm_pkg::cfg_t                         cfg,
	input  logic [sarm_pkg::CH_W-1:0]              channel,
	input  logic signed [sarm_pkg::SMP_W-1:0]      sample,
	input  logic                                   present,
	input  sarm_pkg::acc_t                         acc_in,
	output sarm_pkg::acc_t                         acc_out
);
	import sarm_pkg::*;

	logic hit;
	logic to_board;
	logic to_monitor;

	always_comb begin
		hit        = present && ({1'b0, channel} < (CH_W + 1)'(NUM_CHANNELS));
		to_board   = hit && cfg.board_route[channel];
		to_monitor = hit && cfg.monitor_route[channel];
		acc_out    = acc_in;
		if (to_board) begin
			if (cfg.board_select[channel]) begin
				acc_out.board1 = sat_add(acc_in.board1, sample);
			end else begin
				acc_out.board0 = sat_add(acc_in.board0, sample);
			end
		end
		if (to_monitor) begin
			acc_out.monitor = sat_add(acc_in.monitor, sample);
		end
	end

endmodule

// ===== sv/saturating_audio_router_mixer.sv =====
`timescale 1ns / 1ps
// Top level of the 16-in / 3-out saturating audio router and mixer.
// Depends on sarm_pkg, sarm_ram and sarm_mix.
//
// Usage:
//   Input stream s_*: one sample transaction per channel and position,
//   channel-major. tdata = {sample, position, channel}, tuser = present,
//   tlast = last channel of this position.
//   Output stream m_*: one transaction per input with tlast set, carrying the
//   position and the three saturated bus sums; that accumulator entry is then
//   cleared.
//   Configuration: cfg_we/cfg_index/cfg_wdata write the three routing masks;
//   write them only while no transaction is in flight.
// Timing:
//   An input is taken every cycle unless the input stage stalls. The
//   accumulator RAM is read at acceptance and read-modified-written when the
//   input stage fires, with the most recent write forwarded, so the same
//   position may follow itself back to back. The output is registered.
// Reset:
//   Per-entry valid bits are cleared, so all accumulators read as zero at
//   once; no clearing sweep is needed. Masks reset to zero.
// Stall:
//   The result sits in the output register while m_tready is low; the input
//   stage keeps accepting until an emitting sample finds it still full.
module saturating_audio_router_mixer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,   // channel[3:0], position[10:4], sample[26:11], zero pad
	input  logic                              s_tuser,   // present
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [55:0]                       m_tdata,   // out_position[6:0], board_out0[22:7], board_out1[38:23], monitor_out[54:39], zero pad
	input  logic                              cfg_we,
	input  logic [sarm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sarm_pkg::CFG_W-1:0]        cfg_wdata
);
	import sarm_pkg::*;

	cfg_t cfg_q;

	logic                    s1_valid_q;
	logic [CH_W-1:0]         channel_s1;
	logic [POS_W-1:0]        position_s1;
	logic signed [SMP_W-1:0] sample_s1;
	logic                    present_s1;
	logic                    last_s1;
	logic                    entry_valid_s1;

	logic [BLOCK_SAMPLES-1:0] entry_valid_q;

	logic             fwd_valid_q;
	logic [POS_W-1:0] fwd_pos_q;
	acc_t             fwd_data_q;

	logic             out_valid_q;
	logic [POS_W-1:0] out_pos_q;
	acc_t             out_data_q;

	logic             s_accept;
	logic             s1_fire;
	logic [POS_W-1:0] in_position;
	logic [ACC_W-1:0] ram_rd_data;
	acc_t             acc_cur;
	acc_t             acc_new;
	acc_t             acc_wr;

	assign in_position = s_tdata[10:4];
	assign s1_fire     = s1_valid_q && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready    = !s1_valid_q || s1_fire;
	assign s_accept    = s_tvalid && s_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOARD_ROUTE:  cfg_q.board_route   <= cfg_wdata;
				CFG_BOARD_SELECT: cfg_q.board_select  <= cfg_wdata;
				CFG_MON_ROUTE:    cfg_q.monitor_route <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			channel_s1     <= s_tdata[3:0];
			position_s1    <= in_position;
			sample_s1      <= s_tdata[26:11];
			present_s1     <= s_tuser;
			last_s1        <= s_tlast;
			entry_valid_s1 <= entry_valid_q[in_position];
		end
	end

	sarm_ram #(
		.WIDTH(ACC_W),
		.DEPTH(BLOCK_SAMPLES)
	) u_acc_ram (
		.clk    (clk),
		.wr_en  (s1_fire),
		.wr_addr(position_s1),
		.wr_data(acc_wr),
		.rd_en  (s_accept),
		.rd_addr(in_position),
		.rd_data(ram_rd_data)
	);

	// The forward register always holds the newest write, so a match on it
	// supersedes whatever the RAM returned.
	always_comb begin
		if (fwd_valid_q && (fwd_pos_q == position_s1)) begin
			acc_cur = fwd_data_q;
		end else if (entry_valid_s1) begin
			acc_cur = acc_t'(ram_rd_data);
		end else begin
			acc_cur = '0;
		end
	end

	sarm_mix u_mix (
		.cfg    (cfg_q),
		.channel(channel_s1),
		.sample (sample_s1),
		.present(present_s1),
		.acc_in (acc_cur),
		.acc_out(acc_new)
	);

	assign acc_wr = last_s1 ? '0 : acc_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			fwd_valid_q   <= 1'b0;
		end else if (s1_fire) begin
			entry_valid_q[position_s1] <= 1'b1;
			fwd_valid_q                <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			fwd_pos_q  <= position_s1;
			fwd_data_q <= acc_wr;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			out_pos_q  <= position_s1;
			out_data_q <= acc_new;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_data_q.monitor, out_data_q.board1, out_data_q.board0, out_pos_q};

	// An emitting transaction always lands in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && last_s1 |=> m_tvalid)
		else $error("emitted mix did not reach the output register");

	// The emitted entry is written back as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && last_s1 |=> fwd_valid_q && (fwd_data_q == '0))
		else $error("emitted accumulator entry was not cleared");

	// A stalled input stage must not take a new transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_fire |-> !s_tready)
		else $error("input accepted while stage 1 is stalled");

	// An empty input stage is always ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> s_tready)
		else $error("empty input stage not ready");

endmodule

// ===== bench/saturating_audio_router_mixer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for saturating_audio_router_mixer: a directed table, then random frames,
// most channel-major, under random stalls, with a scoreboard fed by a saturating mix predictor.
// Depends on sarm_pkg and the RTL of the block.
module saturating_audio_router_mixer_tb;
	import sarm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1150;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [CH_W-1:0]         channel;
		logic [POS_W-1:0]        position;
		logic signed [SMP_W-1:0] sample;
		logic                    present;
		logic                    last_ch;
	} mix_in_t;

	typedef struct packed {
		logic [POS_W-1:0]        position;
		logic signed [SMP_W-1:0] board0;
		logic signed [SMP_W-1:0] board1;
		logic signed [SMP_W-1:0] monitor;
	} mix_out_t;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		mix_in_t          item;
		logic [CFG_W-1:0] board_route;
		logic [CFG_W-1:0] board_select;
		logic [CFG_W-1:0] monitor_route;
		bit               typed;
		mix_out_t         typed_mix;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;
	logic                 s_tuser;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [55:0]          m_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	// Mirror of the block: routing masks and the three bus sums per position.
	logic [CFG_W-1:0]        route_board;
	logic [CFG_W-1:0]        sel_board;
	logic [CFG_W-1:0]        route_mon;
	logic signed [SMP_W-1:0] bus0_sum [BLOCK_SAMPLES];
	logic signed [SMP_W-1:0] bus1_sum [BLOCK_SAMPLES];
	logic signed [SMP_W-1:0] mon_sum  [BLOCK_SAMPLES];

	mix_out_t pending_mix[$];
	row_t     dir_tab[$];
	int       mismatches;
	bit       tx_nogap;
	bit       rx_nogap;

	saturating_audio_router_mixer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [SMP_W-1:0] clamp_add(input logic signed [SMP_W-1:0] a,
			input logic signed [SMP_W-1:0] b);
		int s;
		s = int'(a) + int'(b);
		if (s > 32767) s = 32767;
		if (s < -32768) s = -32768;
		return SMP_W'(s);
	endfunction

	// Adds one sample to the routed buses; on the last channel returns the mix and clears it.
	function automatic bit mix_step(input mix_in_t it, output mix_out_t r);
		int p;
		p = int'(it.position);
		r = '0;
		if (it.present && int'(it.channel) < NUM_CHANNELS) begin
			if (route_board[it.channel]) begin
				if (sel_board[it.channel])
					bus1_sum[p] = clamp_add(bus1_sum[p], it.sample);
				else
					bus0_sum[p] = clamp_add(bus0_sum[p], it.sample);
			end
			if (route_mon[it.channel])
				mon_sum[p] = clamp_add(mon_sum[p], it.sample);
		end
		if (!it.last_ch)
			return 1'b0;
		r.position = it.position;
		r.board0   = bus0_sum[p];
		r.board1   = bus1_sum[p];
		r.monitor  = mon_sum[p];
		bus0_sum[p] = '0;
		bus1_sum[p] = '0;
		mon_sum[p]  = '0;
		return 1'b1;
	endfunction

	function automatic int gap_len(input bit nogap);
		int r;
		if (nogap)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SMP_W-1:0] pick_sample();
		int v;
		case ($urandom_range(0, 3))
			0: return SMP_W'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			2: begin
				v = $urandom_range(16384, 32767);
				return $urandom_range(0, 1) ? SMP_W'(v) : SMP_W'(-v - 1);
			end
			default: return SMP_W'(int'($urandom_range(0, 511)) - 256);
		endcase
	endfunction

	function automatic row_t item_row(input int ch, input int pos, input logic [15:0] smp,
			input bit pr, input bit lc, input bit typed, input mix_out_t e);
		row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.item.channel  = CH_W'(ch);
		r.item.position = POS_W'(pos);
		r.item.sample   = smp;
		r.item.present  = pr;
		r.item.last_ch  = lc;
		r.typed = typed;
		r.typed_mix = e;
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [15:0] br, input logic [15:0] bs,
			input logic [15:0] mr);
		row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.board_route   = br;
		r.board_select  = bs;
		r.monitor_route = mr;
		return r;
	endfunction

	task automatic send_sample(input mix_in_t it, input bit typed, input mix_out_t typed_mix);
		mix_out_t r;
		@(negedge clk);
		s_tdata  = {5'd0, it.sample, it.position, it.channel};
		s_tuser  = it.present;
		s_tlast  = it.last_ch;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (mix_step(it, r))
			pending_mix.push_back(typed ? typed_mix : r);
	endtask

	task automatic pause_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
	endtask

	// Lowers valid and waits for every expected mix, then lets the pipeline
	// settle after items that produce nothing.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_mix.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = v;
		case (idx)
			CFG_BOARD_ROUTE:  route_board = v;
			CFG_BOARD_SELECT: sel_board   = v;
			CFG_MON_ROUTE:    route_mon   = v;
			default: ;
		endcase
	endtask

	task automatic set_masks(input logic [CFG_W-1:0] br, input logic [CFG_W-1:0] bs,
			input logic [CFG_W-1:0] mr);
		drain_results();
		write_reg(CFG_BOARD_ROUTE, br);
		write_reg(CFG_BOARD_SELECT, bs);
		write_reg(CFG_MON_ROUTE, mr);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] pick_mask();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return CFG_W'($urandom);
		endcase
	endfunction

	task automatic check_mix(input logic [55:0] d);
		mix_out_t got;
		mix_out_t e;
		got.position = d[6:0];
		got.board0   = d[22:7];
		got.board1   = d[38:23];
		got.monitor  = d[54:39];
		if (pending_mix.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("unexpected mix: pos %0d b0 %0d b1 %0d mon %0d",
					got.position, got.board0, got.board1, got.monitor);
		end else begin
			e = pending_mix.pop_front();
			if (got.position !== e.position || got.board0 !== e.board0 ||
					got.board1 !== e.board1 || got.monitor !== e.monitor) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mix mismatch: exp pos %0d b0 %0d b1 %0d mon %0d, got pos %0d b0 %0d b1 %0d mon %0d",
						e.position, e.board0, e.board1, e.monitor,
						got.position, got.board0, got.board1, got.monitor);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_mix(m_tdata);
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			int n;
			n = gap_len(rx_nogap);
			if (n > 0) begin
				@(negedge clk);
				m_tready = 1'b0;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready = 1'b1;
			repeat ($urandom_range(0, 12)) @(negedge clk);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		int sent;
		int phase;
		int frames;
		int npos;
		int nch;
		int base;
		int stride;
		int n;
		mix_in_t it;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		s_tlast   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		tx_nogap  = 1'b0;
		rx_nogap  = 1'b0;
		mismatches = 0;
		route_board = '0;
		sel_board   = '0;
		route_mon   = '0;
		for (int i = 0; i < BLOCK_SAMPLES; i++) begin
			bus0_sum[i] = '0;
			bus1_sum[i] = '0;
			mon_sum[i]  = '0;
		end

		// Masks are zero after reset, so nothing is routed.
		dir_tab.push_back(item_row(0, 0, 16'h7FFF, 1, 1, 1, '{7'd0, 16'h0, 16'h0, 16'h0}));
		dir_tab.push_back(item_row(15, 127, 16'h8000, 1, 1, 1, '{7'd127, 16'h0, 16'h0, 16'h0}));
		dir_tab.push_back(cfg_row(16'hFFFF, 16'h0000, 16'hFFFF));
		dir_tab.push_back(item_row(0, 1, 16'h7FFF, 1, 0, 0, '0));
		dir_tab.push_back(item_row(1, 1, 16'h7FFF, 1, 1, 1,
			'{7'd1, 16'h7FFF, 16'h0, 16'h7FFF}));
		dir_tab.push_back(item_row(0, 2, 16'h8000, 1, 0, 0, '0));
		dir_tab.push_back(item_row(1, 2, 16'hFFFF, 1, 1, 1,
			'{7'd2, 16'h8000, 16'h0, 16'h8000}));
		// Saturation happens per add, so the later -1 pulls the clipped sum back down.
		dir_tab.push_back(item_row(0, 3, 16'h7FFF, 1, 0, 0, '0));
		dir_tab.push_back(item_row(1, 3, 16'h0001, 1, 0, 0, '0));
		dir_tab.push_back(item_row(2, 3, 16'hFFFF, 1, 1, 1,
			'{7'd3, 16'h7FFE, 16'h0, 16'h7FFE}));
		dir_tab.push_back(item_row(4, 4, 16'h1234, 0, 1, 1, '{7'd4, 16'h0, 16'h0, 16'h0}));
		dir_tab.push_back(cfg_row(16'hFFFF, 16'hFFFF, 16'h0000));
		dir_tab.push_back(item_row(15, 127, 16'h8000, 1, 0, 0, '0));
		dir_tab.push_back(item_row(15, 127, 16'h8000, 1, 1, 1,
			'{7'd127, 16'h0, 16'h8000, 16'h0}));
		dir_tab.push_back(cfg_row(16'h5555, 16'h3333, 16'hAAAA));
		dir_tab.push_back(item_row(5, 10, 16'h0100, 1, 0, 0, '0));
		dir_tab.push_back(item_row(3, 10, 16'h0F00, 1, 0, 0, '0));
		dir_tab.push_back(item_row(5, 10, 16'hC000, 1, 0, 0, '0));
		dir_tab.push_back(item_row(2, 10, 16'h2AAA, 1, 1, 0, '0));
		dir_tab.push_back(item_row(0, 10, 16'h5555, 1, 1, 0, '0));
		dir_tab.push_back(item_row(1, 64, 16'h4000, 1, 0, 0, '0));
		dir_tab.push_back(item_row(1, 64, 16'h4000, 1, 1, 0, '0));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				set_masks(dir_tab[i].board_route, dir_tab[i].board_select,
					dir_tab[i].monitor_route);
			end else begin
				send_sample(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].typed_mix);
				pause_sender(gap_len(1'b0));
			end
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase)
				0: set_masks(16'hFFFF, 16'h0000, 16'hFFFF);
				1: set_masks(16'hFFFF, 16'hFFFF, 16'h0000);
				2: set_masks(16'h0000, 16'h0000, 16'h0000);
				default: set_masks(pick_mask(), pick_mask(), pick_mask());
			endcase
			tx_nogap = ($urandom_range(0, 3) == 0);
			rx_nogap = ($urandom_range(0, 3) == 0);
			frames = $urandom_range(2, 5);
			for (int f = 0; f < frames; f++) begin
				if ($urandom_range(0, 4) != 0) begin
					// Well-formed frame: channels ascending, each over the same positions.
					npos   = $urandom_range(1, 8);
					nch    = $urandom_range(1, NUM_CHANNELS);
					base   = $urandom_range(0, BLOCK_SAMPLES - 1);
					stride = $urandom_range(1, 3);
					for (int ch = 0; ch < nch; ch++) begin
						if (ch != nch - 1 && $urandom_range(0, 5) == 0)
							continue;
						for (int k = 0; k < npos; k++) begin
							it.channel  = CH_W'(ch);
							it.position = POS_W'(base + k * stride);
							it.sample   = pick_sample();
							it.present  = ($urandom_range(0, 9) != 0);
							it.last_ch  = (ch == nch - 1);
							send_sample(it, 1'b0, '0);
							sent++;
							pause_sender(gap_len(tx_nogap));
						end
					end
				end else begin
					n = $urandom_range(1, 12);
					repeat (n) begin
						it.channel  = CH_W'($urandom);
						it.position = POS_W'($urandom);
						it.sample   = pick_sample();
						it.present  = $urandom_range(0, 1);
						it.last_ch  = ($urandom_range(0, 3) == 0);
						send_sample(it, 1'b0, '0);
						sent++;
						pause_sender(gap_len(tx_nogap));
					end
				end
				if ((phase == 3 && f == 0) || $urandom_range(0, 9) == 0)
					drain_results();
			end
			phase++;
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_mix.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== saturating_audio_router_mixer.f =====
sv/sarm_pkg.sv
sv/sarm_ram.sv
sv/sarm_mix.sv
sv/saturating_audio_router_mixer.sv
bench/saturating_audio_router_mixer_tb.sv
